/* rtl/gsa_pkg.sv */
`default_nettype none

package gsa_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned IDX_FW   = 10;
	localparam int unsigned GEN_W    = 32;
	localparam int unsigned STATUS_W = 2;

	// command codes; the unused code behaves as a query
	localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DEAD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RSVD = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_FW-1:0] slot_index;
		logic [GEN_W-1:0]  slot_gen;
	} req_t;

	typedef struct packed {
		logic [IDX_FW-1:0]   out_index;
		logic [GEN_W-1:0]    out_gen;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/gsa_ram.sv */
`default_nettype none

module gsa_ram #(
	parameter int unsigned WIDTH = 33,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/generational_slot_allocator_top.sv */
`default_nettype none

// Generational slot allocator.
// Request channel (req_valid/req_ready/req) carries a command, a slot index
// and a generation; the response channel (rsp_valid/rsp_ready/rsp) returns
// exactly one transaction per request, in order.
// Create hands out the most recently freed slot with its generation bumped
// (skipping 0), or else the next never-used slot with generation 1; with no
// slot left it answers full. Destroy frees a live matching handle. Query
// reports whether a handle is live.
// Flow: each request is accepted, then executed; a create that reuses a
// freed slot adds a pop step in between, since the free stack read
// yields the slot index that then addresses the slot memory. Both tables are
// synchronous RAMs with separate read and write ports and a registered read;
// each request reads, modifies and writes back before the next one is accepted.
// Reset clears the counters and the response register; no clearing pass
// runs, since slot contents beyond the used count are never used.
// A stalled receiver holds the result in the output register; the block
// still accepts one more request and finishes it once the register frees.

module generational_slot_allocator_top #(
	parameter int unsigned MAX_SLOTS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire gsa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output gsa_pkg::rsp_t      rsp
);

	localparam int unsigned IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CMP_W  = (CNT_W > gsa_pkg::IDX_FW) ? CNT_W : gsa_pkg::IDX_FW;
	localparam int unsigned GEN_W  = gsa_pkg::GEN_W;
	localparam int unsigned SLOT_W = GEN_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_EXEC
	} state_t;

	state_t state_q;

	logic [gsa_pkg::CMD_W-1:0]  cmd_q;
	logic [gsa_pkg::IDX_FW-1:0] idx_q;
	logic [GEN_W-1:0]           gen_q;

	logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
	logic [CNT_W-1:0] used_cnt_q, used_cnt_d;

	logic          rsp_valid_q;
	gsa_pkg::rsp_t rsp_q, rsp_d;

	logic accept, advance;

	logic              slot_we, slot_re;
	logic [IDX_W-1:0]  slot_waddr, slot_raddr;
	logic [SLOT_W-1:0] slot_wdata, slot_rdata;

	logic             stk_we, stk_re;
	logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	logic             rd_live;
	logic [GEN_W-1:0] rd_gen, next_gen;
	logic             handle_live;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign advance   = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	// read ports: request index at accept, popped stack entry in the pop step
	assign slot_re    = accept || (state_q == S_POP);
	assign slot_raddr = (state_q == S_POP) ? stk_rdata : IDX_W'(req.slot_index);
	assign stk_re     = accept;
	assign stk_raddr  = IDX_W'(free_cnt_q - CNT_W'(1));

	assign rd_live = slot_rdata[GEN_W];
	assign rd_gen  = slot_rdata[GEN_W-1:0];

	always_comb begin
		next_gen = rd_gen + GEN_W'(1);
		if (next_gen == '0) begin
			next_gen = GEN_W'(1);
		end
	end

	assign handle_live = (gen_q != '0) && (CMP_W'(idx_q) < CMP_W'(used_cnt_q))
		&& rd_live && (rd_gen == gen_q);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = IDX_W'(idx_q);
		slot_wdata = {1'b0, rd_gen};
		stk_we     = 1'b0;
		stk_waddr  = IDX_W'(free_cnt_q);
		stk_wdata  = IDX_W'(idx_q);
		free_cnt_d = free_cnt_q;
		used_cnt_d = used_cnt_q;
		rsp_d.out_index = idx_q;
		rsp_d.out_gen   = gen_q;
		rsp_d.status    = gsa_pkg::ST_DEAD;

		unique case (cmd_q)
			gsa_pkg::CMD_CREATE: begin
				if (free_cnt_q != '0) begin
					slot_waddr      = stk_rdata;
					slot_wdata      = {1'b1, next_gen};
					slot_we         = advance;
					free_cnt_d      = free_cnt_q - CNT_W'(1);
					rsp_d.out_index = gsa_pkg::IDX_FW'(stk_rdata);
					rsp_d.out_gen   = next_gen;
					rsp_d.status    = gsa_pkg::ST_OK;
				end else if (used_cnt_q < CNT_W'(MAX_SLOTS)) begin
					slot_waddr      = IDX_W'(used_cnt_q);
					slot_wdata      = {1'b1, GEN_W'(1)};
					slot_we         = advance;
					used_cnt_d      = used_cnt_q + CNT_W'(1);
					rsp_d.out_index = gsa_pkg::IDX_FW'(used_cnt_q);
					rsp_d.out_gen   = GEN_W'(1);
					rsp_d.status    = gsa_pkg::ST_OK;
				end else begin
					rsp_d.status = gsa_pkg::ST_FULL;
				end
			end
			gsa_pkg::CMD_DESTROY: begin
				if (handle_live && (free_cnt_q < CNT_W'(MAX_SLOTS))) begin
					slot_we      = advance;
					stk_we       = advance;
					free_cnt_d   = free_cnt_q + CNT_W'(1);
					rsp_d.status = gsa_pkg::ST_OK;
				end
			end
			default: begin
				rsp_d.status = handle_live ? gsa_pkg::ST_OK : gsa_pkg::ST_DEAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			idx_q <= req.slot_index;
			gen_q <= req.slot_gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_cnt_q  <= '0;
			used_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((req.cmd == gsa_pkg::CMD_CREATE) && (free_cnt_q != '0)) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_POP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (advance) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (advance) begin
				free_cnt_q  <= free_cnt_d;
				used_cnt_q  <= used_cnt_d;
				rsp_q       <= rsp_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	gsa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	gsa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_SLOTS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

endmodule

`default_nettype wire

/* rtl/gsa_checker.sv */
`default_nettype none

module gsa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire gsa_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire gsa_pkg::rsp_t rsp
);

	// a stalled response transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	// a fresh response only follows a cycle of work
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a request in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != gsa_pkg::ST_RSVD)
		else $error("reserved status code");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (.*);

`default_nettype wire
